### src/rotary_encoder_with_button_assert.svh
// assertion macros shared by the encoder rtl
`ifndef ROTARY_ENCODER_WITH_BUTTON_ASSERT_SVH
`define ROTARY_ENCODER_WITH_BUTTON_ASSERT_SVH

// same-cycle implication, checked outside reset
`define REB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// next-cycle implication, checked outside reset
`define REB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

### src/reb_pkg.sv
// types and constants of the rotary encoder with button
`default_nettype none

package reb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_READ_VALUE = 2'd1,
        CMD_READ_BTN   = 2'd2,
        CMD_CAPTURE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_OPEN     = 3'd0,
        EV_CLICKED  = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_HELD     = 3'd3,
        EV_RELEASED = 3'd4
    } ev_t;

    localparam logic [2:0] REG_STEPS_PER_NOTCH = 3'd0;
    localparam logic [2:0] REG_CHECK_INTERVAL  = 3'd1;
    localparam logic [2:0] REG_HOLD_CHECKS     = 3'd2;
    localparam logic [2:0] REG_DCLICK_CHECKS   = 3'd3;
    localparam logic [2:0] REG_ACCEL_INC       = 3'd4;
    localparam logic [2:0] REG_ACCEL_DEC       = 3'd5;
    localparam logic [2:0] REG_ACCEL_TOP       = 3'd6;

    localparam logic [2:0]  RST_STEPS_PER_NOTCH = 3'd4;
    localparam logic [7:0]  RST_CHECK_INTERVAL  = 8'd10;
    localparam logic [11:0] RST_HOLD_CHECKS     = 12'd120;
    localparam logic [7:0]  RST_DCLICK_CHECKS   = 8'd60;
    localparam logic [11:0] RST_ACCEL_INC       = 12'd25;
    localparam logic [11:0] RST_ACCEL_DEC       = 12'd2;
    localparam logic [14:0] RST_ACCEL_TOP       = 15'd3072;

    typedef struct packed {
        logic [2:0]  steps_per_notch;
        logic [7:0]  check_interval;
        logic [11:0] hold_checks;
        logic [7:0]  double_click_checks;
        logic [11:0] accel_increment;
        logic [11:0] accel_decrement;
        logic [14:0] accel_top;
    } cfg_t;

    typedef struct packed {
        logic check;
        logic pressed;
        logic read;
    } btn_ctrl_t;

endpackage

`default_nettype wire

### src/reb_button.sv
// button debounce state: key down count, double click countdown, pending event
`default_nettype none

`include "rotary_encoder_with_button_assert.svh"

module reb_button
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire reb_pkg::btn_ctrl_t ctrl,
    input  wire logic [11:0]       hold_checks,
    input  wire logic [7:0]        double_click_checks,
    output      reb_pkg::ev_t      pending_event
);
    import reb_pkg::*;

    logic [15:0] key_down_reg;
    logic [15:0] key_down_next;
    logic [7:0]  dclick_reg;
    logic [7:0]  dclick_next;
    logic [7:0]  dclick_mid;
    ev_t         event_reg;
    ev_t         event_next;

    always_comb
    begin
        key_down_next = key_down_reg;
        dclick_mid    = dclick_reg;
        dclick_next   = dclick_reg;
        event_next    = event_reg;
        if (ctrl.read && event_reg != EV_HELD)
        begin
            event_next = EV_OPEN;
        end
        if (ctrl.check)
        begin
            if (ctrl.pressed)
            begin
                if (key_down_reg != 16'hffff)
                begin
                    key_down_next = key_down_reg + 16'd1;
                end
                if (key_down_next > {4'd0, hold_checks})
                begin
                    event_next = EV_HELD;
                end
            end
            else
            begin
                if (key_down_reg != 16'd0)
                begin
                    if (event_reg == EV_HELD)
                    begin
                        event_next = EV_RELEASED;
                        dclick_mid = 8'd0;
                    end
                    else if (dclick_reg > 8'd1)
                    begin
                        if (dclick_reg < double_click_checks)
                        begin
                            event_next = EV_DOUBLE;
                            dclick_mid = 8'd0;
                        end
                    end
                    else
                    begin
                        dclick_mid = double_click_checks;
                    end
                end
                key_down_next = 16'd0;
            end
            dclick_next = dclick_mid;
            if (dclick_mid != 8'd0)
            begin
                dclick_next = dclick_mid - 8'd2;
                if (dclick_next == 8'd0)
                begin
                    event_next = EV_CLICKED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg <= '0;
            dclick_reg   <= '0;
            event_reg    <= EV_OPEN;
        end
        else
        begin
            key_down_reg <= key_down_next;
            dclick_reg   <= dclick_next;
            event_reg    <= event_next;
        end
    end

    assign pending_event = event_reg;

    `REB_ASSERT_NEXT(a_release_after_hold,
        ctrl.check && !ctrl.pressed && key_down_reg != 16'd0 && event_reg == EV_HELD,
        event_reg == EV_RELEASED)
    `REB_ASSERT_NEXT(a_read_clears_event,
        ctrl.read && !ctrl.check && event_reg != EV_HELD,
        event_reg == EV_OPEN)
    `REB_ASSERT_NEXT(a_key_clear_on_release,
        ctrl.check && !ctrl.pressed,
        key_down_reg == 16'd0)

endmodule

`default_nettype wire

### src/rotary_encoder_with_button.sv
// top level: rotary quadrature encoder decoder with push button
// usage
//   s_axis: one command per transaction; tuser holds the command (tick, read
//   value, read button, capture pins), tdata holds the sampled pins
//   m_axis: one result transaction for each read value or read button command,
//   none for tick or capture
//   cfg: register writes, index and data, taken on cfg_valid with cfg_ready
//   always high; write only while no command is in flight
// timing
//   a command is taken into an input register, processed in the next cycle
//   and its result is on m_axis from the clock edge after acceptance
//   one command per cycle is sustained; the state update for a command is a
//   single pass of small adders and compares between the input register and
//   the state and result registers
// reset
//   all state clears, registers return to their defaults, both channels empty
// stalls
//   with m_axis_tready low the result register holds; ticks and captures still
//   pass, but a further read waits in the input register and s_axis_tready
//   drops until the result is taken
`default_nettype none

`include "rotary_encoder_with_button_assert.svh"

module rotary_encoder_with_button
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pin_a, pin_b, pin_button, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // command
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // value, button_event, zero pad
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    import reb_pkg::*;

    cfg_t        cfg_reg;

    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic        in_a_reg;
    logic        in_b_reg;
    logic        in_btn_reg;

    logic              out_valid_reg;
    logic signed [8:0] out_value_reg;
    logic signed [8:0] out_value_next;
    logic [2:0]        out_event_reg;
    logic [2:0]        out_event_next;

    logic [1:0]  last_phase_reg;
    logic [1:0]  last_phase_next;
    logic [15:0] step_count_reg;
    logic [15:0] step_count_next;
    logic [15:0] accel_level_reg;
    logic [15:0] accel_level_next;
    logic [7:0]  tick_divider_reg;
    logic [7:0]  tick_divider_next;

    logic        s_accept;
    logic        has_result;
    logic        advance;
    logic        is_tick;
    logic        do_check;
    logic [1:0]  phase;
    logic [1:0]  phase_diff;
    logic [15:0] accel_sub;
    logic [15:0] accel_decayed;
    logic [7:0]  divider_inc;
    logic signed [16:0] accel_room;
    logic        room_ok;
    logic [8:0]  magnitude;
    logic        step_neg;
    logic        step_whole;
    btn_ctrl_t   btn_ctrl;
    ev_t         pending_event;

    // handshake and pipeline control
    assign has_result    = in_cmd_reg == CMD_READ_VALUE || in_cmd_reg == CMD_READ_BTN;
    assign advance       = in_valid_reg && (!has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign is_tick       = advance && in_cmd_reg == CMD_TICK;

    // encoder phase and acceleration
    assign phase         = {in_a_reg, in_a_reg ^ in_b_reg};
    assign phase_diff    = last_phase_reg - phase;
    assign accel_sub     = accel_level_reg - {4'd0, cfg_reg.accel_decrement};
    assign accel_decayed = accel_sub[15] ? 16'd0 : accel_sub;
    assign accel_room    = $signed({2'b00, cfg_reg.accel_top})
                           - $signed({5'b00000, cfg_reg.accel_increment});
    assign room_ok       = $signed({1'b0, accel_decayed}) <= accel_room;
    assign divider_inc   = tick_divider_reg + 8'd1;
    assign do_check      = divider_inc >= cfg_reg.check_interval;

    // value read
    assign magnitude = 9'd1 + {1'b0, accel_level_reg[15:8]};
    assign step_neg  = step_count_reg[15];

    always_comb
    begin
        case (cfg_reg.steps_per_notch)
            3'd2:    step_whole = |step_count_reg[14:1];
            3'd4:    step_whole = |step_count_reg[14:2];
            default: step_whole = |step_count_reg[14:0];
        endcase
    end

    always_comb
    begin
        last_phase_next   = last_phase_reg;
        step_count_next   = step_count_reg;
        accel_level_next  = accel_level_reg;
        tick_divider_next = tick_divider_reg;
        out_value_next    = '0;
        out_event_next    = EV_OPEN;
        if (advance)
        begin
            case (in_cmd_reg)
                CMD_TICK:
                begin
                    accel_level_next = accel_decayed;
                    if (phase_diff[0])
                    begin
                        last_phase_next = phase;
                        step_count_next = (phase_diff == 2'd3) ? step_count_reg + 16'd1
                                                               : step_count_reg - 16'd1;
                        if (room_ok)
                        begin
                            accel_level_next = accel_decayed + {4'd0, cfg_reg.accel_increment};
                        end
                    end
                    tick_divider_next = do_check ? 8'd0 : divider_inc;
                end
                CMD_READ_VALUE:
                begin
                    case (cfg_reg.steps_per_notch)
                        3'd2:    step_count_next = {15'd0, step_count_reg[0]};
                        3'd4:    step_count_next = {14'd0, step_count_reg[1:0]};
                        default: step_count_next = 16'd0;
                    endcase
                    if (step_neg)
                    begin
                        out_value_next = -$signed(magnitude);
                    end
                    else if (step_whole)
                    begin
                        out_value_next = $signed(magnitude);
                    end
                end
                CMD_READ_BTN:
                begin
                    out_event_next = pending_event;
                end
                CMD_CAPTURE:
                begin
                    last_phase_next = phase;
                end
                default:
                begin
                    last_phase_next = last_phase_reg;
                end
            endcase
        end
    end

    assign btn_ctrl.check   = is_tick && do_check;
    assign btn_ctrl.pressed = !in_btn_reg;
    assign btn_ctrl.read    = advance && in_cmd_reg == CMD_READ_BTN;

    reb_button u_button
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctrl                (btn_ctrl),
        .hold_checks         (cfg_reg.hold_checks),
        .double_click_checks (cfg_reg.double_click_checks),
        .pending_event       (pending_event)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_notch     <= RST_STEPS_PER_NOTCH;
            cfg_reg.check_interval      <= RST_CHECK_INTERVAL;
            cfg_reg.hold_checks         <= RST_HOLD_CHECKS;
            cfg_reg.double_click_checks <= RST_DCLICK_CHECKS;
            cfg_reg.accel_increment     <= RST_ACCEL_INC;
            cfg_reg.accel_decrement     <= RST_ACCEL_DEC;
            cfg_reg.accel_top           <= RST_ACCEL_TOP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEPS_PER_NOTCH: cfg_reg.steps_per_notch     <= cfg_data[2:0];
                REG_CHECK_INTERVAL:  cfg_reg.check_interval      <= cfg_data[7:0];
                REG_HOLD_CHECKS:     cfg_reg.hold_checks         <= cfg_data[11:0];
                REG_DCLICK_CHECKS:   cfg_reg.double_click_checks <= cfg_data[7:0];
                REG_ACCEL_INC:       cfg_reg.accel_increment     <= cfg_data[11:0];
                REG_ACCEL_DEC:       cfg_reg.accel_decrement     <= cfg_data[11:0];
                REG_ACCEL_TOP:       cfg_reg.accel_top           <= cfg_data[14:0];
                default:             cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_phase_reg   <= '0;
            step_count_reg   <= '0;
            accel_level_reg  <= '0;
            tick_divider_reg <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            last_phase_reg   <= last_phase_next;
            step_count_reg   <= step_count_next;
            accel_level_reg  <= accel_level_next;
            tick_divider_reg <= tick_divider_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_a_reg   <= s_axis_tdata[0];
            in_b_reg   <= s_axis_tdata[1];
            in_btn_reg <= s_axis_tdata[2];
        end
        if (advance && has_result)
        begin
            out_value_reg <= out_value_next;
            out_event_reg <= out_event_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_event_reg, out_value_reg};

    `REB_ASSERT_NOW(a_accel_in_range, 1'b1, !accel_level_reg[15])
    `REB_ASSERT_NEXT(a_divider_restart, is_tick && do_check, tick_divider_reg == 8'd0)
    `REB_ASSERT_NOW(a_one_field_per_result,
        out_valid_reg && out_event_reg != 3'd0, out_value_reg == 9'sd0)

endmodule

`default_nettype wire
